FILE: design/mpps_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpps_pkg
// Widths, register indexes, mode codes and reset values shared by the
// multipath packet path selector and its result channel interface.
// ----------------------------------------------------------------------------
package mpps_pkg;

    localparam int SEQ_W      = 32;
    localparam int PATH_W     = 8;
    localparam int TRAIN_W    = 32;
    localparam int GAP_W      = 16;
    localparam int MODE_W     = 2;
    localparam int PC_W       = 9;
    localparam int TL_W       = 9;
    localparam int BL_W       = 13;
    localparam int TCNT_W     = 9;
    localparam int BCNT_W     = 16;
    localparam int PROD_W     = PC_W + TL_W;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam int MAX_PATHS_DEF = 256;
    localparam int PATH_CAP      = 256;
    localparam int TRAIN_CAP     = 256;

    localparam logic [MODE_W-1:0] MODE_SPRAY   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_BLOCK   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_FLOWLET = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_MODE         = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PATH_COUNT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TRAIN_LENGTH = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BURST_LENGTH = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PACKET_TOTAL = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SEND_GAP     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_BURST_GAP    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_GAP    = 3'd7;

    localparam logic [MODE_W-1:0] RST_MODE         = MODE_SPRAY;
    localparam logic [PC_W-1:0]   RST_PATH_COUNT   = 9'd256;
    localparam logic [TL_W-1:0]   RST_TRAIN_LENGTH = 9'd16;
    localparam logic [BL_W-1:0]   RST_BURST_LENGTH = 13'd16;
    localparam logic [SEQ_W-1:0]  RST_PACKET_TOTAL = 32'd16384;
    localparam logic [GAP_W-1:0]  RST_SEND_GAP     = 16'd10;
    localparam logic [GAP_W-1:0]  RST_BURST_GAP    = 16'd610;
    localparam logic [GAP_W-1:0]  RST_BLOCK_GAP    = 16'd610;

    localparam logic [BL_W-1:0] BURST_SAT = 13'd8191;

    typedef logic [PATH_W-1:0] t_path;

endpackage

FILE: design/mpps_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpps_in_if
// Request channel: one send slot per request.
// ----------------------------------------------------------------------------
interface mpps_in_if;
    logic valid;
    logic ready;
    logic send_slot;

    modport source (output valid, output send_slot, input ready);
    modport sink   (input valid, input send_slot, output ready);
endinterface

FILE: design/mpps_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpps_out_if
// Result channel: path assignment, train id and gap for one send slot.
// ----------------------------------------------------------------------------
interface mpps_out_if;
    import mpps_pkg::*;

    logic               valid;
    logic               ready;
    logic               sent;
    logic [SEQ_W-1:0]   sequence_res;
    t_path              path_index;
    logic [TRAIN_W-1:0] train_number;
    logic [GAP_W-1:0]   next_gap_us;
    logic               finished;

    modport source (output valid, output sent, output sequence_res, output path_index,
                    output train_number, output next_gap_us, output finished,
                    input ready);
    modport sink   (input valid, input sent, input sequence_res, input path_index,
                    input train_number, input next_gap_us, input finished,
                    output ready);
endinterface

FILE: design/multipath_packet_path_selector_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multipath_packet_path_selector_core
// Assigns each send slot a path (spray, block rotation or flowlet bursts),
// a train id and the gap before the next send.
// ----------------------------------------------------------------------------
//  channel   dir  handshake      payload
//  i_req     in   valid/ready    send_slot
//  o_res     out  valid/ready    sent, sequence_res, path_index, train_number,
//                                next_gap_us, finished
//  i_cfg_*   in   write enable   register index, write data (no read-back)
//
//  One request per clock while the result channel is not stalled; a request
//  passes the input register, then the path/counter logic (one 9x9 multiply
//  for the block size and its compare) into the result register.
//  An idle slot (send_slot = 0) is consumed and gives no result.
//  Synchronous active-low reset restores the register defaults and clears
//  all counters. A stalled result holds in its register while one more
//  request waits in the input register.
// ----------------------------------------------------------------------------
module multipath_packet_path_selector_core #(
    parameter int MAX_PATHS = mpps_pkg::MAX_PATHS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    mpps_in_if.sink                          i_req,
    mpps_out_if.source                       o_res,
    input  logic                             i_cfg_we,
    input  logic [mpps_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [mpps_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import mpps_pkg::*;

    localparam int LIM_I = (MAX_PATHS > PATH_CAP) ? PATH_CAP :
                           ((MAX_PATHS < 1) ? 1 : MAX_PATHS);
    localparam logic [PC_W-1:0] PATH_LIM  = PC_W'(LIM_I);
    localparam logic [TL_W-1:0] TRAIN_LIM = TL_W'(TRAIN_CAP);

    function automatic t_path wrap_inc(input t_path v, input logic [PC_W-1:0] n);
        logic [PC_W-1:0] s;
        s = {1'b0, v} + 1'b1;
        return (s >= n) ? '0 : s[PATH_W-1:0];
    endfunction

    // configuration registers
    logic [MODE_W-1:0] r_mode;
    logic [PC_W-1:0]   r_path_count;
    logic [TL_W-1:0]   r_train_length;
    logic [BL_W-1:0]   r_burst_length;
    logic [SEQ_W-1:0]  r_packet_total;
    logic [GAP_W-1:0]  r_send_gap;
    logic [GAP_W-1:0]  r_burst_gap;
    logic [GAP_W-1:0]  r_block_gap;

    // state
    logic [SEQ_W-1:0]   r_next_seq,   n_next_seq;
    logic [TRAIN_W-1:0] r_train_id,   n_train_id;
    logic [TCNT_W-1:0]  r_in_train,   n_in_train;
    logic [BL_W-1:0]    r_in_burst,   n_in_burst;
    t_path              r_flow_path,  n_flow_path;
    t_path              r_spray_path, n_spray_path;
    logic [BCNT_W-1:0]  r_in_block,   n_in_block;
    t_path              r_block_path, n_block_path;

    // input and result registers
    logic               r_s1_valid;
    logic               r_s1_slot;
    logic               r_o_valid;
    logic               r_o_sent;
    logic [SEQ_W-1:0]   r_o_seq;
    t_path              r_o_path;
    logic [TRAIN_W-1:0] r_o_train;
    logic [GAP_W-1:0]   r_o_gap;
    logic               r_o_finished;

    logic               out_free;
    logic               s1_move;
    logic               s1_result;
    logic               at_total;
    logic               advance;
    logic [PC_W-1:0]    pc;
    logic [TL_W-1:0]    tl;
    logic [PROD_W-1:0]  block_size;
    logic [PROD_W-1:0]  nb;
    t_path              sp, bp, fp;
    logic               flow_switch;
    logic [BL_W-1:0]    burst_base;
    logic [TCNT_W-1:0]  tcnt;
    t_path              n_o_path;
    logic               done;
    logic [GAP_W-1:0]   n_o_gap;

    assign out_free  = !r_o_valid || o_res.ready;
    assign s1_move   = r_s1_valid && (!r_s1_slot || out_free);
    assign s1_result = r_s1_valid && r_s1_slot && out_free;
    assign at_total  = r_next_seq >= r_packet_total;
    assign advance   = s1_result && !at_total;

    assign i_req.ready = !r_s1_valid || s1_move;

    always_comb begin
        pc = (r_path_count == '0) ? PC_W'(1) : r_path_count;
        if (pc > PATH_LIM) begin
            pc = PATH_LIM;
        end
        tl = (r_train_length == '0) ? TL_W'(1) : r_train_length;
        if (tl > TRAIN_LIM) begin
            tl = TRAIN_LIM;
        end
        block_size = PROD_W'(pc) * PROD_W'(tl);

        // drop stale path counters left over from a larger path count
        sp = ({1'b0, r_spray_path} >= pc) ? '0 : r_spray_path;
        bp = ({1'b0, r_block_path} >= pc) ? '0 : r_block_path;
        fp = ({1'b0, r_flow_path}  >= pc) ? '0 : r_flow_path;

        flow_switch = (r_mode == MODE_FLOWLET) && (r_in_burst >= r_burst_length);
        n_flow_path = flow_switch ? wrap_inc(fp, pc) : fp;
        burst_base  = flow_switch ? '0 : r_in_burst;

        unique case (r_mode)
            MODE_BLOCK:   n_o_path = bp;
            MODE_FLOWLET: n_o_path = n_flow_path;
            default:      n_o_path = sp;
        endcase

        n_next_seq   = r_next_seq + 1'b1;
        n_spray_path = wrap_inc(sp, pc);
        nb           = PROD_W'(r_in_block) + 1'b1;
        if (nb >= block_size) begin
            n_in_block   = '0;
            n_block_path = wrap_inc(bp, pc);
        end else begin
            n_in_block   = nb[BCNT_W-1:0];
            n_block_path = bp;
        end
        n_in_burst = (burst_base < BURST_SAT) ? burst_base + 1'b1 : burst_base;
        tcnt       = r_in_train + 1'b1;
        if (tcnt >= tl) begin
            n_train_id = r_train_id + 1'b1;
            n_in_train = '0;
        end else begin
            n_train_id = r_train_id;
            n_in_train = tcnt;
        end

        done    = n_next_seq >= r_packet_total;
        n_o_gap = '0;
        if (!done) begin
            n_o_gap = r_send_gap;
            unique case (r_mode)
                MODE_BLOCK: begin
                    if (n_in_block == '0) n_o_gap = r_block_gap;
                end
                MODE_FLOWLET: begin
                    if (n_in_burst >= r_burst_length) n_o_gap = r_burst_gap;
                end
                default: begin
                end
            endcase
        end
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode         <= RST_MODE;
            r_path_count   <= RST_PATH_COUNT;
            r_train_length <= RST_TRAIN_LENGTH;
            r_burst_length <= RST_BURST_LENGTH;
            r_packet_total <= RST_PACKET_TOTAL;
            r_send_gap     <= RST_SEND_GAP;
            r_burst_gap    <= RST_BURST_GAP;
            r_block_gap    <= RST_BLOCK_GAP;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_MODE:         r_mode         <= i_cfg_data[MODE_W-1:0];
                CFG_PATH_COUNT:   r_path_count   <= i_cfg_data[PC_W-1:0];
                CFG_TRAIN_LENGTH: r_train_length <= i_cfg_data[TL_W-1:0];
                CFG_BURST_LENGTH: r_burst_length <= i_cfg_data[BL_W-1:0];
                CFG_PACKET_TOTAL: r_packet_total <= i_cfg_data[SEQ_W-1:0];
                CFG_SEND_GAP:     r_send_gap     <= i_cfg_data[GAP_W-1:0];
                CFG_BURST_GAP:    r_burst_gap    <= i_cfg_data[GAP_W-1:0];
                CFG_BLOCK_GAP:    r_block_gap    <= i_cfg_data[GAP_W-1:0];
            endcase
        end
    end

    // counters advance only on an assigned packet
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_next_seq   <= '0;
            r_train_id   <= '0;
            r_in_train   <= '0;
            r_in_burst   <= '0;
            r_flow_path  <= '0;
            r_spray_path <= '0;
            r_in_block   <= '0;
            r_block_path <= '0;
        end else if (advance) begin
            r_next_seq   <= n_next_seq;
            r_train_id   <= n_train_id;
            r_in_train   <= n_in_train;
            r_in_burst   <= n_in_burst;
            r_flow_path  <= n_flow_path;
            r_spray_path <= n_spray_path;
            r_in_block   <= n_in_block;
            r_block_path <= n_block_path;
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_req.valid && i_req.ready) begin
            r_s1_valid <= 1'b1;
        end else if (s1_move) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_s1_slot <= i_req.send_slot;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (s1_result) begin
            r_o_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_result) begin
            if (at_total) begin
                r_o_sent     <= 1'b0;
                r_o_seq      <= '0;
                r_o_path     <= '0;
                r_o_train    <= '0;
                r_o_gap      <= '0;
                r_o_finished <= 1'b1;
            end else begin
                r_o_sent     <= 1'b1;
                r_o_seq      <= r_next_seq;
                r_o_path     <= n_o_path;
                r_o_train    <= r_train_id;
                r_o_gap      <= n_o_gap;
                r_o_finished <= done;
            end
        end
    end

    assign o_res.valid        = r_o_valid;
    assign o_res.sent         = r_o_sent;
    assign o_res.sequence_res = r_o_seq;
    assign o_res.path_index   = r_o_path;
    assign o_res.train_number = r_o_train;
    assign o_res.next_gap_us  = r_o_gap;
    assign o_res.finished     = r_o_finished;

endmodule

FILE: bench/tb_multipath_packet_path_selector_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_multipath_packet_path_selector_core
// Self-checking bench for the path selector core. A few directed settings
// cover reset values, the path/train/burst limits, the unused mode, a run
// past the packet total and the last packet. Random settings then run about
// two thousand send slots with random stalls on both channels. A scoreboard
// class predicts each result and compares it field by field in order.
// ----------------------------------------------------------------------------
module tb_multipath_packet_path_selector_core;
    import mpps_pkg::*;

    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
    localparam int                RUN_SLOTS   = 1950;
    localparam int                HOLD_CYCLES = 60;

    typedef struct packed {
        logic               sent;
        logic [SEQ_W-1:0]   seq;
        t_path              path;
        logic [TRAIN_W-1:0] train;
        logic [GAP_W-1:0]   gap;
        logic               finished;
    } t_slot_result;

    class path_scoreboard;
        logic [MODE_W-1:0]  mode;
        logic [PC_W-1:0]    path_count;
        logic [TL_W-1:0]    train_length;
        logic [BL_W-1:0]    burst_length;
        logic [SEQ_W-1:0]   packet_total;
        logic [GAP_W-1:0]   send_gap;
        logic [GAP_W-1:0]   burst_gap;
        logic [GAP_W-1:0]   block_gap;
        logic [SEQ_W-1:0]   next_seq;
        logic [TRAIN_W-1:0] train_id;
        int unsigned        train_cnt;
        int unsigned        burst_cnt;
        int unsigned        block_cnt;
        int unsigned        spray_path;
        int unsigned        flow_path;
        int unsigned        block_path;
        t_slot_result       expected_q[$];
        int                 mismatches;

        function new();
            mode         = RST_MODE;
            path_count   = RST_PATH_COUNT;
            train_length = RST_TRAIN_LENGTH;
            burst_length = RST_BURST_LENGTH;
            packet_total = RST_PACKET_TOTAL;
            send_gap     = RST_SEND_GAP;
            burst_gap    = RST_BURST_GAP;
            block_gap    = RST_BLOCK_GAP;
            next_seq     = '0;
            train_id     = '0;
            train_cnt    = 0;
            burst_cnt    = 0;
            block_cnt    = 0;
            spray_path   = 0;
            flow_path    = 0;
            block_path   = 0;
            mismatches   = 0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_MODE:         mode         = data[MODE_W-1:0];
                CFG_PATH_COUNT:   path_count   = data[PC_W-1:0];
                CFG_TRAIN_LENGTH: train_length = data[TL_W-1:0];
                CFG_BURST_LENGTH: burst_length = data[BL_W-1:0];
                CFG_PACKET_TOTAL: packet_total = data[SEQ_W-1:0];
                CFG_SEND_GAP:     send_gap     = data[GAP_W-1:0];
                CFG_BURST_GAP:    burst_gap    = data[GAP_W-1:0];
                CFG_BLOCK_GAP:    block_gap    = data[GAP_W-1:0];
                default: ;
            endcase
        endfunction

        function int unsigned paths_in_use();
            int unsigned lim;
            int unsigned p;
            lim = (MAX_PATHS_DEF > PATH_CAP) ? PATH_CAP : MAX_PATHS_DEF;
            if (lim < 1) lim = 1;
            p = 32'(path_count);
            if (p < 1) p = 1;
            if (p > lim) p = lim;
            return p;
        endfunction

        function int unsigned train_in_use();
            int unsigned t;
            t = 32'(train_length);
            if (t < 1) t = 1;
            if (t > TRAIN_CAP) t = TRAIN_CAP;
            return t;
        endfunction

        // advance a path counter, folding a stale value back to zero first
        function int unsigned next_path(int unsigned v, int unsigned n);
            if (v >= n) v = 0;
            v = v + 1;
            return (v >= n) ? 0 : v;
        endfunction

        function void note_request(logic slot);
            int unsigned  pc;
            int unsigned  tl;
            int unsigned  block_size;
            int unsigned  nb;
            int unsigned  path;
            logic         done;
            t_slot_result r;
            if (!slot) return;
            r = '0;
            if (next_seq >= packet_total) begin
                r.finished = 1'b1;
                expected_q = {expected_q, r};
                return;
            end
            pc         = paths_in_use();
            tl         = train_in_use();
            block_size = pc * tl;
            if (spray_path >= pc) spray_path = 0;
            if (block_path >= pc) block_path = 0;
            if (flow_path >= pc) flow_path = 0;

            case (mode)
                MODE_BLOCK: path = block_path;
                MODE_FLOWLET: begin
                    if (burst_cnt >= burst_length) begin
                        flow_path = next_path(flow_path, pc);
                        burst_cnt = 0;
                    end
                    path = flow_path;
                end
                default: path = spray_path;
            endcase

            r.sent  = 1'b1;
            r.seq   = next_seq;
            r.path  = t_path'(path);
            r.train = train_id;

            next_seq   = next_seq + 1'b1;
            spray_path = next_path(spray_path, pc);
            nb = block_cnt + 1;
            if (nb >= block_size) begin
                block_cnt  = 0;
                block_path = next_path(block_path, pc);
            end else begin
                block_cnt = nb;
            end
            if (burst_cnt < BURST_SAT) burst_cnt = burst_cnt + 1;
            train_cnt = train_cnt + 1;
            if (train_cnt >= tl) begin
                train_id  = train_id + 1'b1;
                train_cnt = 0;
            end

            done = (next_seq >= packet_total);
            if (!done) begin
                r.gap = send_gap;
                if (mode == MODE_BLOCK) begin
                    if (block_cnt == 0) r.gap = block_gap;
                end else if (mode == MODE_FLOWLET) begin
                    if (burst_cnt >= burst_length) r.gap = burst_gap;
                end
            end
            r.finished = done;
            expected_q = {expected_q, r};
        endfunction

        function void note_mismatch(string what, logic [31:0] want, logic [31:0] got);
            mismatches++;
            if (mismatches <= 10)
                $display("ERROR %0t ns: %s expected 0x%0h got 0x%0h", $time, what, want, got);
        endfunction

        function void check_result(t_slot_result got);
            t_slot_result want;
            if (expected_q.size() == 0) begin
                note_mismatch("result with no request pending, seq", '0, got.seq);
                return;
            end
            want = expected_q.pop_front();
            if (got.sent !== want.sent)
                note_mismatch("sent", 32'(want.sent), 32'(got.sent));
            if (got.seq !== want.seq) note_mismatch("sequence_res", want.seq, got.seq);
            if (got.path !== want.path)
                note_mismatch("path_index", 32'(want.path), 32'(got.path));
            if (got.train !== want.train) note_mismatch("train_number", want.train, got.train);
            if (got.gap !== want.gap)
                note_mismatch("next_gap_us", 32'(want.gap), 32'(got.gap));
            if (got.finished !== want.finished)
                note_mismatch("finished", 32'(want.finished), 32'(got.finished));
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    mpps_in_if  req_if ();
    mpps_out_if res_if ();

    path_scoreboard sb;
    int             hold_reqs   = 0;
    int             hold_seen   = 0;
    int             hold_left   = 0;
    bit             tx_idle_en  = 1'b1;
    bit             rx_idle_en  = 1'b1;
    int             slots_sent  = 0;

    multipath_packet_path_selector_core uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (req_if),
        .o_res      (res_if),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // receiver: random stalls, plus a counted hold-off when one is requested
    always @(posedge i_clk) begin
        if (hold_seen != hold_reqs) begin
            hold_seen = hold_reqs;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            res_if.ready <= 1'b0;
            hold_left = hold_left - 1;
        end else begin
            res_if.ready <= !rx_idle_en || ($urandom_range(0, 99) >= 15);
        end
    end

    always @(posedge i_clk) begin
        t_slot_result got;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            got.sent     = res_if.sent;
            got.seq      = res_if.sequence_res;
            got.path     = res_if.path_index;
            got.train    = res_if.train_number;
            got.gap      = res_if.next_gap_us;
            got.finished = res_if.finished;
            sb.check_result(got);
        end
    end

    initial begin
        #2_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    task automatic push_slot(input logic slot);
        req_if.valid     <= 1'b1;
        req_if.send_slot <= slot;
        do @(posedge i_clk); while (!req_if.ready);
        sb.note_request(slot);
        slots_sent++;
    endtask

    task automatic idle_gap();
        while (tx_idle_en && $urandom_range(0, 99) < 15) begin
            req_if.valid     <= 1'b0;
            req_if.send_slot <= 1'($urandom);
            @(posedge i_clk);
        end
    endtask

    // drop valid and hold until every pending request has produced its result
    task automatic settle();
        req_if.valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge i_clk);
        sb.write_reg(idx, data);
    endtask

    task automatic program_regs(input logic [31:0] mode_v, input logic [31:0] pc_v,
                                input logic [31:0] tl_v, input logic [31:0] bl_v,
                                input logic [31:0] total_v, input logic [31:0] send_v,
                                input logic [31:0] burst_v, input logic [31:0] block_v);
        cfg_write(CFG_MODE, mode_v);
        cfg_write(CFG_PATH_COUNT, pc_v);
        cfg_write(CFG_TRAIN_LENGTH, tl_v);
        cfg_write(CFG_BURST_LENGTH, bl_v);
        cfg_write(CFG_PACKET_TOTAL, total_v);
        cfg_write(CFG_SEND_GAP, send_v);
        cfg_write(CFG_BURST_GAP, burst_v);
        cfg_write(CFG_BLOCK_GAP, block_v);
        cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // sometimes fill the bits above the register width with noise
    function automatic logic [31:0] with_junk(logic [31:0] v, int w);
        if (w < 32 && $urandom_range(0, 3) == 0) return v | ($urandom << w);
        return v;
    endfunction

    function automatic logic [31:0] rand_gap();
        case ($urandom_range(0, 5))
            0:       return 32'd0;
            1:       return 32'd65535;
            2:       return $urandom_range(0, 20);
            default: return $urandom_range(0, 65535);
        endcase
    endfunction

    task automatic random_setting(input int len);
        logic [31:0] m;
        logic [31:0] pc;
        logic [31:0] tl;
        logic [31:0] bl;
        logic [31:0] tot;
        int          r;
        case ($urandom_range(0, 9))
            0, 1, 2: m = 32'(MODE_SPRAY);
            3, 4, 5: m = 32'(MODE_BLOCK);
            6, 7, 8: m = 32'(MODE_FLOWLET);
            default: m = 32'(MODE_UNUSED);
        endcase
        case ($urandom_range(0, 9))
            0:       pc = 1;
            1:       pc = 2;
            2, 3, 4: pc = $urandom_range(1, 8);
            5, 6:    pc = $urandom_range(1, 256);
            7:       pc = 256;
            8:       pc = 0;
            default: pc = $urandom_range(257, 511);
        endcase
        case ($urandom_range(0, 9))
            0:       tl = 1;
            1, 2, 3: tl = $urandom_range(1, 8);
            4, 5:    tl = $urandom_range(1, 32);
            6:       tl = 256;
            7:       tl = $urandom_range(1, 256);
            8:       tl = 0;
            default: tl = $urandom_range(257, 511);
        endcase
        case ($urandom_range(0, 9))
            0:       bl = 0;
            1:       bl = 1;
            2, 3, 4: bl = $urandom_range(1, 8);
            5, 6:    bl = $urandom_range(1, 64);
            7:       bl = 4096;
            8:       bl = $urandom_range(1, 8191);
            default: bl = 8191;
        endcase
        r = $urandom_range(0, 19);
        if (r == 0)
            tot = '0;
        else if (r <= 2)
            tot = $urandom;
        else if (r <= 10)
            tot = sb.next_seq + $urandom_range(len / 2, len * 2);
        else
            tot = '1;
        program_regs(with_junk(m, MODE_W), with_junk(pc, PC_W), with_junk(tl, TL_W),
                     with_junk(bl, BL_W), tot, with_junk(rand_gap(), GAP_W),
                     with_junk(rand_gap(), GAP_W), with_junk(rand_gap(), GAP_W));
    endtask

    initial begin
        int phase;
        int len;
        int k;
        sb = new();
        i_rst_n          <= 1'b0;
        req_if.valid     <= 1'b0;
        req_if.send_slot <= 1'b0;
        cfg_we           <= 1'b0;
        cfg_idx          <= CFG_MODE;
        cfg_data         <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset defaults, with an ignored slot in between
        push_slot(1'b1);
        push_slot(1'b0);
        push_slot(1'b1);
        push_slot(1'b1);
        push_slot(1'b1);
        settle();

        // flowlet, burst length zero, stale spray path, run past the total
        program_regs(32'(MODE_FLOWLET), 3, 2, 0, sb.next_seq + 4, 7, 65535, 0);
        push_slot(1'b1);
        push_slot(1'b1);
        push_slot(1'b0);
        push_slot(1'b1);
        push_slot(1'b1);
        push_slot(1'b1);
        push_slot(1'b1);
        settle();

        // unused mode, zero path count and train length
        program_regs(32'(MODE_UNUSED), 0, 0, 1, 32'hFFFF_FFFF, 65535, 1, 2);
        repeat (4) push_slot(1'b1);
        settle();

        // block rotation over two paths with the smallest train length
        program_regs(32'(MODE_BLOCK), 2, 1, 4096, 32'hFFFF_FFFF, 0, 0, 65535);
        repeat (5) push_slot(1'b1);
        settle();

        // saturated limits and a zero total
        program_regs(32'(MODE_SPRAY), 511, 511, 8191, 0, 1, 2, 3);
        repeat (2) push_slot(1'b1);
        settle();

        phase = 0;
        while (slots_sent < RUN_SLOTS) begin
            len = (phase % 5 == 4) ? $urandom_range(150, 300) : $urandom_range(30, 120);
            random_setting(len);
            tx_idle_en = (phase != 1);
            rx_idle_en = (phase != 1);
            for (k = 0; k < len && slots_sent < RUN_SLOTS; k++) begin
                // long receiver hold-off while requests keep coming
                if (phase == 2 && k == 20) hold_reqs++;
                // pause the sender until the pipe is empty
                if (phase == 3 && k == len / 2) settle();
                idle_gap();
                push_slot($urandom_range(0, 9) != 0);
            end
            settle();
            phase++;
        end

        repeat (10) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

FILE: files.f
design/mpps_pkg.sv
design/mpps_in_if.sv
design/mpps_out_if.sv
design/multipath_packet_path_selector_core.sv
bench/tb_multipath_packet_path_selector_core.sv
